// ----- src/tsd_pkg.sv -----
// Shared constants, configuration register indexes, datapath operation codes and status bundle for the spike detector.
`default_nettype none
package tsd_pkg;

  localparam int DEFAULT_HISTORY_DEPTH = 1024;
  localparam int DEFAULT_SAMPLE_BITS   = 16;
  localparam int THR_BITS              = 16;
  localparam int POS_BITS              = 32;
  localparam int WIN_BITS              = 7;
  localparam int SKIP_BITS             = 10;
  localparam int CFG_IDX_BITS          = 3;
  localparam int CFG_DATA_BITS         = 16;
  localparam int NUM_CH                = 4;

  localparam logic [POS_BITS-1:0]  CHECK_START = 32'd32;
  localparam logic [WIN_BITS-1:0]  WIN_MIN     = 7'd4;
  localparam logic [WIN_BITS-1:0]  WIN_MAX     = 7'd64;
  localparam logic [THR_BITS-1:0]  THR_RESET   = 16'sh7fff;
  localparam logic [WIN_BITS-1:0]  WIN_RESET   = 7'd32;
  localparam logic [SKIP_BITS-1:0] SKIP_RESET  = 10'd32;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_THR_CH1 = 3'd0,
    CFG_THR_CH2 = 3'd1,
    CFG_THR_CH3 = 3'd2,
    CFG_THR_CH4 = 3'd3,
    CFG_WINDOW  = 3'd4,
    CFG_SKIP    = 3'd5
  } cfg_idx_t;

  // commands from the controller to the datapath
  typedef enum logic [3:0] {
    DP_NOP,
    DP_WRITE,
    DP_CHECK_RD,
    DP_HIT,
    DP_ADVANCE,
    DP_ALIGN_RD,
    DP_NEXT_CHAN,
    DP_SCAN_INIT,
    DP_SCAN_RD,
    DP_SCAN_STEP,
    DP_ALIGN_END,
    DP_SNIP_INIT,
    DP_SNIP_RD,
    DP_SNIP_EMIT
  } dp_op_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic check_arrived;
    logic hit;
    logic sel_over;
    logic end_arrived;
    logic chan_last;
    logic scan_last;
    logic snip_arrived;
    logic snip_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- src/tsd_datapath.sv -----
// Datapath: sample history memory, position registers, peak search and output register.
`default_nettype none
module tsd_datapath #(
  parameter int HISTORY_DEPTH = tsd_pkg::DEFAULT_HISTORY_DEPTH,
  parameter int SAMPLE_BITS   = tsd_pkg::DEFAULT_SAMPLE_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire tsd_pkg::dp_op_t                     op,
  output tsd_pkg::dp_status_t                      status,
  input  wire logic signed [SAMPLE_BITS-1:0]       in_sample_ch1,
  input  wire logic signed [SAMPLE_BITS-1:0]       in_sample_ch2,
  input  wire logic signed [SAMPLE_BITS-1:0]       in_sample_ch3,
  input  wire logic signed [SAMPLE_BITS-1:0]       in_sample_ch4,
  input  wire logic                                in_record_start,
  input  wire logic                                cfg_valid,
  input  wire logic [tsd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [tsd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [tsd_pkg::POS_BITS-1:0]             out_spike_position,
  output logic signed [SAMPLE_BITS-1:0]            out_snippet_ch1,
  output logic signed [SAMPLE_BITS-1:0]            out_snippet_ch2,
  output logic signed [SAMPLE_BITS-1:0]            out_snippet_ch3,
  output logic signed [SAMPLE_BITS-1:0]            out_snippet_ch4,
  output logic                                     out_snippet_last
);

  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int WORD = tsd_pkg::NUM_CH * SAMPLE_BITS;
  localparam int EXT  = ((SAMPLE_BITS > tsd_pkg::THR_BITS) ? SAMPLE_BITS : tsd_pkg::THR_BITS) + 1;
  localparam int PB   = tsd_pkg::POS_BITS;
  localparam logic [AW-1:0] DEPTH_LO = AW'(HISTORY_DEPTH);
  localparam logic [AW-1:0] WPTR_MAX = AW'(HISTORY_DEPTH - 1);

  logic [WORD-1:0] mem [HISTORY_DEPTH];
  logic [WORD-1:0] rd_data_r;

  logic [AW-1:0] wptr_r, last_addr_r;
  logic [PB-1:0] count_r, last_r, ncp_r, sp_r, best_pos_r;
  logic [1:0]    chan_r;
  logic [6:0]    j_r;
  logic [5:0]    k_r;
  logic signed [SAMPLE_BITS-1:0] best_val_r;

  logic [tsd_pkg::THR_BITS-1:0]  thr_r [tsd_pkg::NUM_CH];
  logic [tsd_pkg::WIN_BITS-1:0]  window_r;
  logic [tsd_pkg::SKIP_BITS-1:0] skip_r;

  logic out_valid_r;

  // effective window and derived lengths
  logic [6:0] w;
  logic [7:0] w2;
  logic [4:0] quarter;
  logic [8:0] w3;
  logic [7:0] cnt;
  logic [9:0] skip_eff;

  always_comb begin
    if (window_r < tsd_pkg::WIN_MIN)      w = tsd_pkg::WIN_MIN;
    else if (window_r > tsd_pkg::WIN_MAX) w = tsd_pkg::WIN_MAX;
    else                                  w = window_r;
    w2       = {w, 1'b0};
    quarter  = w[6:2];
    w3       = {1'b0, w, 1'b0} + {2'b00, w};
    cnt      = {3'b000, quarter} + {1'b0, w3[8:2]};
    skip_eff = (skip_r == '0) ? 10'd1 : skip_r;
  end

  // positions of interest
  logic [PB-1:0] scan_pos, snip_start, snip_pos, end_pos, snip_end;
  assign scan_pos   = sp_r + PB'(j_r);
  assign snip_start = sp_r - PB'(quarter) - PB'(1);
  assign snip_pos   = snip_start + PB'(k_r);
  assign end_pos    = sp_r + PB'(w2) - PB'(1);
  assign snip_end   = snip_start + PB'(cnt) - PB'(1);

  logic [PB-1:0] d_check, d_end, d_snip;
  assign d_check = last_r - ncp_r;
  assign d_end   = last_r - end_pos;
  assign d_snip  = last_r - snip_end;

  // read address: offset back from where the latest sample lives
  logic [PB-1:0] rd_pos, rd_diff;
  logic [AW:0]   rd_tmp;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  always_comb begin
    case (op)
      tsd_pkg::DP_CHECK_RD: rd_pos = ncp_r;
      tsd_pkg::DP_SCAN_RD:  rd_pos = scan_pos;
      tsd_pkg::DP_SNIP_RD:  rd_pos = snip_pos;
      default:              rd_pos = sp_r;
    endcase
    rd_en   = (op == tsd_pkg::DP_CHECK_RD) || (op == tsd_pkg::DP_ALIGN_RD) ||
              (op == tsd_pkg::DP_SCAN_RD)  || (op == tsd_pkg::DP_SNIP_RD);
    rd_diff = last_r - rd_pos;
    rd_tmp  = {1'b0, last_addr_r} - {1'b0, rd_diff[AW-1:0]};
    rd_addr = rd_tmp[AW] ? (rd_tmp[AW-1:0] + DEPTH_LO) : rd_tmp[AW-1:0];
  end

  // history memory
  always_ff @(posedge clk) begin
    if (op == tsd_pkg::DP_WRITE) begin
      mem[wptr_r] <= {in_sample_ch4, in_sample_ch3, in_sample_ch2, in_sample_ch1};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // channel compares on the read word
  logic signed [SAMPLE_BITS-1:0] rd_ch [tsd_pkg::NUM_CH];
  logic [tsd_pkg::NUM_CH-1:0]    over;

  for (genvar i = 0; i < tsd_pkg::NUM_CH; i++) begin : g_ch
    logic signed [EXT-1:0] s_ext, t_ext;
    assign rd_ch[i] = rd_data_r[i*SAMPLE_BITS +: SAMPLE_BITS];
    assign s_ext    = {{(EXT-SAMPLE_BITS){rd_ch[i][SAMPLE_BITS-1]}}, rd_ch[i]};
    assign t_ext    = {{(EXT-tsd_pkg::THR_BITS){thr_r[i][tsd_pkg::THR_BITS-1]}}, thr_r[i]};
    assign over[i]  = s_ext > t_ext;
  end

  logic signed [SAMPLE_BITS-1:0] sel_val;
  assign sel_val = rd_ch[chan_r];

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    status.check_arrived = !d_check[PB-1];
    status.hit           = |over;
    status.sel_over      = over[chan_r];
    status.end_arrived   = !d_end[PB-1];
    status.chan_last     = (chan_r == 2'd3);
    status.scan_last     = ({1'b0, j_r} == (w2 - 8'd1));
    status.snip_arrived  = !d_snip[PB-1];
    status.snip_last     = ({2'b00, k_r} == (cnt - 8'd1));
    status.out_free      = out_free;
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r      <= '0;
      count_r     <= '0;
      last_r      <= '0;
      ncp_r       <= tsd_pkg::CHECK_START;
      chan_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < tsd_pkg::NUM_CH; i++) thr_r[i] <= tsd_pkg::THR_RESET;
      window_r    <= tsd_pkg::WIN_RESET;
      skip_r      <= tsd_pkg::SKIP_RESET;
    end else begin
      // take configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          tsd_pkg::CFG_THR_CH1: thr_r[0] <= cfg_data;
          tsd_pkg::CFG_THR_CH2: thr_r[1] <= cfg_data;
          tsd_pkg::CFG_THR_CH3: thr_r[2] <= cfg_data;
          tsd_pkg::CFG_THR_CH4: thr_r[3] <= cfg_data;
          tsd_pkg::CFG_WINDOW:  window_r <= cfg_data[tsd_pkg::WIN_BITS-1:0];
          tsd_pkg::CFG_SKIP:    skip_r   <= cfg_data[tsd_pkg::SKIP_BITS-1:0];
          default: ;
        endcase
      end

      // drop the output transaction once taken
      if (op == tsd_pkg::DP_SNIP_EMIT) out_valid_r <= 1'b1;
      else if (!out_stall)             out_valid_r <= 1'b0;

      case (op)
        tsd_pkg::DP_WRITE: begin
          last_addr_r <= wptr_r;
          wptr_r      <= (wptr_r == WPTR_MAX) ? '0 : wptr_r + AW'(1);
          if (in_record_start) begin
            last_r  <= '0;
            count_r <= PB'(1);
            ncp_r   <= tsd_pkg::CHECK_START;
          end else begin
            last_r  <= count_r;
            count_r <= count_r + PB'(1);
          end
        end
        tsd_pkg::DP_HIT: begin
          sp_r   <= ncp_r;
          chan_r <= '0;
        end
        tsd_pkg::DP_ADVANCE:   ncp_r  <= ncp_r + PB'(1);
        tsd_pkg::DP_NEXT_CHAN: chan_r <= chan_r + 2'd1;
        tsd_pkg::DP_SCAN_INIT: begin
          best_val_r <= sel_val;
          best_pos_r <= sp_r;
          j_r        <= '0;
        end
        tsd_pkg::DP_SCAN_STEP: begin
          if (sel_val > best_val_r) begin
            best_val_r <= sel_val;
            best_pos_r <= scan_pos;
          end
          j_r <= j_r + 7'd1;
        end
        tsd_pkg::DP_ALIGN_END: begin
          sp_r   <= best_pos_r;
          chan_r <= chan_r + 2'd1;
        end
        tsd_pkg::DP_SNIP_INIT: k_r <= '0;
        tsd_pkg::DP_SNIP_EMIT: begin
          k_r <= k_r + 6'd1;
          if (status.snip_last) ncp_r <= sp_r + PB'(skip_eff);
        end
        default: ;
      endcase
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (op == tsd_pkg::DP_SNIP_EMIT) begin
      out_spike_position <= sp_r;
      out_snippet_ch1    <= rd_ch[0];
      out_snippet_ch2    <= rd_ch[1];
      out_snippet_ch3    <= rd_ch[2];
      out_snippet_ch4    <= rd_ch[3];
      out_snippet_last   <= status.snip_last;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ----- src/tsd_ctrl.sv -----
// Controller: sequences check, peak alignment and snippet output for each sample.
`default_nettype none
module tsd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_record_start,
  output logic                     in_stall,
  input  wire tsd_pkg::dp_status_t status,
  output tsd_pkg::dp_op_t          op
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK_ADDR, S_CHK_EVAL, S_AL_ADDR, S_AL_EVAL,
    S_SC_ADDR, S_SC_EVAL, S_AL_DONE, S_SN_TEST, S_SN_ADDR, S_SN_OUT
  } state_t;

  typedef enum logic [1:0] { M_CHECK, M_ALIGN, M_SNIP } mode_t;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    op        = tsd_pkg::DP_NOP;
    case (state_r)
      S_IDLE: begin
        // write the sample, then resume where the last item left off
        if (in_valid) begin
          op = tsd_pkg::DP_WRITE;
          if (in_record_start) begin
            mode_nxt  = M_CHECK;
            state_nxt = S_CHK_ADDR;
          end else begin
            case (mode_r)
              M_ALIGN: state_nxt = S_AL_ADDR;
              M_SNIP:  state_nxt = S_SN_TEST;
              default: state_nxt = S_CHK_ADDR;
            endcase
          end
        end
      end
      S_CHK_ADDR: begin
        if (status.check_arrived) begin
          op        = tsd_pkg::DP_CHECK_RD;
          state_nxt = S_CHK_EVAL;
        end else begin
          mode_nxt  = M_CHECK;
          state_nxt = S_IDLE;
        end
      end
      S_CHK_EVAL: begin
        if (status.hit) begin
          op        = tsd_pkg::DP_HIT;
          state_nxt = S_AL_ADDR;
        end else begin
          op        = tsd_pkg::DP_ADVANCE;
          state_nxt = S_CHK_ADDR;
        end
      end
      S_AL_ADDR: begin
        op        = tsd_pkg::DP_ALIGN_RD;
        state_nxt = S_AL_EVAL;
      end
      S_AL_EVAL: begin
        if (!status.sel_over) begin
          op        = tsd_pkg::DP_NEXT_CHAN;
          state_nxt = status.chan_last ? S_SN_TEST : S_AL_ADDR;
        end else if (!status.end_arrived) begin
          mode_nxt  = M_ALIGN;
          state_nxt = S_IDLE;
        end else begin
          op        = tsd_pkg::DP_SCAN_INIT;
          state_nxt = S_SC_ADDR;
        end
      end
      S_SC_ADDR: begin
        op        = tsd_pkg::DP_SCAN_RD;
        state_nxt = S_SC_EVAL;
      end
      S_SC_EVAL: begin
        op        = tsd_pkg::DP_SCAN_STEP;
        state_nxt = status.scan_last ? S_AL_DONE : S_SC_ADDR;
      end
      S_AL_DONE: begin
        op        = tsd_pkg::DP_ALIGN_END;
        state_nxt = status.chan_last ? S_SN_TEST : S_AL_ADDR;
      end
      S_SN_TEST: begin
        if (status.snip_arrived) begin
          op        = tsd_pkg::DP_SNIP_INIT;
          state_nxt = S_SN_ADDR;
        end else begin
          mode_nxt  = M_SNIP;
          state_nxt = S_IDLE;
        end
      end
      S_SN_ADDR: begin
        op        = tsd_pkg::DP_SNIP_RD;
        state_nxt = S_SN_OUT;
      end
      S_SN_OUT: begin
        // hold the read word until the output register frees up
        if (status.out_free) begin
          op = tsd_pkg::DP_SNIP_EMIT;
          if (status.snip_last) begin
            mode_nxt  = M_CHECK;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SN_ADDR;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= M_CHECK;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/tetrode_spike_detector.sv -----
// Top level of the tetrode spike detector: controller plus datapath.
//
// Usage: one four-channel sample is a transaction on the in_ channel
// (in_valid/in_stall); record_start restarts the record position at zero.
// Each spike yields a snippet of transactions on the out_ channel
// (out_valid/out_stall), all carrying the aligned peak position, the last
// one flagged by out_snippet_last. Thresholds, window and skip are written
// through cfg_valid/cfg_ready/cfg_index/cfg_data; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// Memory use: every read goes through a registered read port. A sample
// with no trigger needs only the threshold check; alignment reads each
// channel and runs a peak search for each channel over threshold; a
// snippet takes one memory read per output sample, all through the single
// history memory port.
// Reset clears positions, restarts checking at position 32 and restores
// register defaults; the history memory is not cleared. A stalled receiver
// holds the output register and pauses the snippet, and in_stall stays high
// until the block has finished its work on the current sample.
`default_nettype none
module tetrode_spike_detector #(
  parameter int HISTORY_DEPTH = tsd_pkg::DEFAULT_HISTORY_DEPTH,
  parameter int SAMPLE_BITS   = tsd_pkg::DEFAULT_SAMPLE_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]     in_sample_ch1,
  input  wire logic signed [SAMPLE_BITS-1:0]     in_sample_ch2,
  input  wire logic signed [SAMPLE_BITS-1:0]     in_sample_ch3,
  input  wire logic signed [SAMPLE_BITS-1:0]     in_sample_ch4,
  input  wire logic                              in_record_start,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tsd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [tsd_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [tsd_pkg::POS_BITS-1:0]           out_spike_position,
  output logic signed [SAMPLE_BITS-1:0]          out_snippet_ch1,
  output logic signed [SAMPLE_BITS-1:0]          out_snippet_ch2,
  output logic signed [SAMPLE_BITS-1:0]          out_snippet_ch3,
  output logic signed [SAMPLE_BITS-1:0]          out_snippet_ch4,
  output logic                                   out_snippet_last
);

  tsd_pkg::dp_op_t     op;
  tsd_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  tsd_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_record_start (in_record_start),
    .in_stall        (in_stall),
    .status          (status),
    .op              (op)
  );

  tsd_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .op                 (op),
    .status             (status),
    .in_sample_ch1      (in_sample_ch1),
    .in_sample_ch2      (in_sample_ch2),
    .in_sample_ch3      (in_sample_ch3),
    .in_sample_ch4      (in_sample_ch4),
    .in_record_start    (in_record_start),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_spike_position (out_spike_position),
    .out_snippet_ch1    (out_snippet_ch1),
    .out_snippet_ch2    (out_snippet_ch2),
    .out_snippet_ch3    (out_snippet_ch3),
    .out_snippet_ch4    (out_snippet_ch4),
    .out_snippet_last   (out_snippet_last)
  );

endmodule
`default_nettype wire

// ----- src/tsd_checker.sv -----
// Port-level checker for the spike detector and its bind.
`default_nettype none
module tsd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_spike_position,
  input wire logic        out_snippet_last
);

  // a stalled output transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output transaction dropped while stalled");

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid just after reset");

  // inputs wait while a snippet is still being sent
  a_snip_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_snippet_last |-> in_stall)
    else $error("input taken in the middle of a snippet");

  // one snippet carries one peak position
  a_same_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_snippet_last |=>
      (!out_valid || out_spike_position == $past(out_spike_position)))
    else $error("peak position changed within a snippet");

endmodule

bind tetrode_spike_detector tsd_checker u_tsd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_spike_position (out_spike_position),
  .out_snippet_last   (out_snippet_last)
);
`default_nettype wire
